/* hw/rtl/cardinal_spline_point_generator_defines.svh */
// Assertion macros shared by the cardinal spline point generator RTL.
`ifndef CARDINAL_SPLINE_POINT_GENERATOR_DEFINES_SVH
`define CARDINAL_SPLINE_POINT_GENERATOR_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define CSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define CSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/csp_pkg.sv */
// Types and constants shared by the cardinal spline point generator.
package csp_pkg;

  localparam int COORD_W    = 16;
  localparam int TENSION_W  = 16;
  localparam int SUBDIV_W   = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TENSION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBDIV  = 1'd1;

  localparam logic [TENSION_W-1:0] TENSION_RST = 16'd8192;
  localparam logic [SUBDIV_W-1:0]  SUBDIV_RST  = 6'd16;

  // t in Q0.16, one extra bit so that t = 1.0 at the segment end fits
  localparam int            T_W   = 17;
  localparam logic [T_W-1:0] T_ONE = 17'h10000;
  localparam int            CNT_W = 5;

  // shared multiplier: coefficient/accumulator by tension or t
  localparam int COEF_W       = 40;
  localparam int MULB_W       = T_W + 1;
  localparam int PROD_W       = COEF_W + MULB_W;
  localparam int HORNER_SHIFT = 16;
  localparam int FRAC_SHIFT   = 14;
  localparam int ROUND_BIAS   = 1 << (FRAC_SHIFT - 1);

  // datapath phases
  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] SU_LATCH   = 3'd0;
  localparam logic [PH_W-1:0] SU_MUL_AX  = 3'd1;
  localparam logic [PH_W-1:0] SU_MUL_AY  = 3'd2;
  localparam logic [PH_W-1:0] SU_MUL_BX  = 3'd3;
  localparam logic [PH_W-1:0] SU_MUL_BY  = 3'd4;
  localparam logic [PH_W-1:0] SU_MUL_GX  = 3'd5;
  localparam logic [PH_W-1:0] SU_MUL_GY  = 3'd6;
  localparam logic [PH_W-1:0] SU_LAST    = 3'd7;
  localparam logic [PH_W-1:0] EV_MUL_AX  = 3'd0;
  localparam logic [PH_W-1:0] EV_MUL_AY  = 3'd1;
  localparam logic [PH_W-1:0] EV_MUL_HX1 = 3'd2;
  localparam logic [PH_W-1:0] EV_MUL_HY1 = 3'd3;
  localparam logic [PH_W-1:0] EV_MUL_HX2 = 3'd4;
  localparam logic [PH_W-1:0] EV_MUL_HY2 = 3'd5;
  localparam logic [PH_W-1:0] EV_LAST    = 3'd6;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic [T_W-1:0]            tval_t;

  typedef struct packed {
    coord_t p0;
    coord_t p1;
    coord_t p2;
    coord_t p3;
  } csp_quad_t;

  typedef struct packed {
    logic            setup;
    logic            eval;
    logic [PH_W-1:0] phase;
  } csp_dp_ctrl_t;

endpackage

/* hw/rtl/csp_point_if.sv */
// Control point item channel.
interface csp_point_if import csp_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   start_track;

  modport source (output valid, output point_x, output point_y, output start_track,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input start_track,
                output ready);
endinterface

/* hw/rtl/csp_curve_if.sv */
// Curve point item channel.
interface csp_curve_if import csp_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t curve_x;
  coord_t curve_y;
  logic   run_end;

  modport source (output valid, output curve_x, output curve_y, output run_end,
                  input ready);
  modport sink (input valid, input curve_x, input curve_y, input run_end,
                output ready);
endinterface

/* hw/rtl/cardinal_spline_point_generator.sv */
// Top level of the cardinal spline point generator: sequencer, window, ports.
// Control points come in one item at a time; start_track clears the window.
// An item that only fills the window is just stored. An item that closes a
// segment holds the input off while its curve is made: an accept step, a step
// for the track's extra leading point, setup (the 17-step divider that finds
// 65536/N runs beside the six tension products of the coefficients, and setup
// waits for it), then per curve point a t step, six products on the one shared
// 40x18 multiplier interleaved over x and y, and one emit, and last a step to
// slide the window. The output can stall a segment. With N at zero the segment
// skips setup entirely. A curve point waits in the output register, so the
// sequencer only stalls when that register is still full.
`include "cardinal_spline_point_generator_defines.svh"

module cardinal_spline_point_generator import csp_pkg::*; #(
  parameter int MAX_SUBDIVISIONS = 63
) (
  input  logic                  clk,
  input  logic                  rst_n,
  csp_point_if.sink             in_ch,
  csp_curve_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int N_W       = $clog2(MAX_SUBDIVISIONS + 1);
  localparam int WIN_DEPTH = 3;
  localparam logic [1:0] WIN_FULL = 2'd3;

  localparam int S_W = 3;
  localparam logic [S_W-1:0] S_IDLE  = 3'd0;
  localparam logic [S_W-1:0] S_FIRST = 3'd1;
  localparam logic [S_W-1:0] S_SETUP = 3'd2;
  localparam logic [S_W-1:0] S_STEP  = 3'd3;
  localparam logic [S_W-1:0] S_EVAL  = 3'd4;
  localparam logic [S_W-1:0] S_EMIT  = 3'd5;
  localparam logic [S_W-1:0] S_SHIFT = 3'd6;

  logic [S_W-1:0]       state_r, state_nxt;
  logic [PH_W-1:0]      ph_r, ph_nxt;
  logic [N_W-1:0]       k_r, k_nxt;
  logic [1:0]           seen_r, seen_nxt;
  logic                 first_done_r, first_done_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [N_W-1:0]       n_r;
  logic [TENSION_W-1:0] tension_r;
  logic [SUBDIV_W-1:0]  subdiv_r;
  coord_t               win_x_r [WIN_DEPTH];
  coord_t               win_y_r [WIN_DEPTH];
  coord_t               px_r;
  coord_t               py_r;
  coord_t               curve_x_r;
  coord_t               curve_y_r;
  logic                 run_end_r;

  logic                 in_fire;
  logic                 out_free;
  logic                 load_first;
  logic                 load_curve;
  logic [1:0]           seen_eff;
  logic [N_W-1:0]       n_eff;
  logic                 t_ready;
  tval_t                t_val;
  csp_dp_ctrl_t         dp_ctrl;
  csp_quad_t            quad_x;
  csp_quad_t            quad_y;
  coord_t               dp_x;
  coord_t               dp_y;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign load_first  = (state_r == S_FIRST) && out_free;
  assign load_curve  = (state_r == S_EMIT) && out_free;
  assign seen_eff    = in_ch.start_track ? 2'd0 : seen_r;

  // subdivision count above the build limit is clamped to it
  always_comb begin
    if (int'(subdiv_r) > MAX_SUBDIVISIONS) begin
      n_eff = N_W'(MAX_SUBDIVISIONS);
    end else begin
      n_eff = N_W'(subdiv_r);
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    ph_nxt         = ph_r;
    k_nxt          = k_r;
    seen_nxt       = seen_r;
    first_done_nxt = first_done_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (seen_eff != WIN_FULL) begin
            seen_nxt       = seen_eff + 2'd1;
            first_done_nxt = in_ch.start_track ? 1'b0 : first_done_r;
          end else begin
            k_nxt  = '0;
            ph_nxt = '0;
            if (!first_done_r) begin
              state_nxt = S_FIRST;
            end else if (n_eff == '0) begin
              state_nxt = S_SHIFT;
            end else begin
              state_nxt = S_SETUP;
            end
          end
        end
      end
      S_FIRST: begin
        if (out_free) begin
          first_done_nxt = 1'b1;
          state_nxt      = (n_r == '0) ? S_SHIFT : S_SETUP;
        end
      end
      S_SETUP: begin
        if (ph_r != SU_LAST) begin
          ph_nxt = PH_W'(ph_r + 1'b1);
        end else if (t_ready) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        state_nxt = S_EVAL;
        ph_nxt    = '0;
        k_nxt     = N_W'(k_r + 1'b1);
      end
      S_EVAL: begin
        if (ph_r == EV_LAST) begin
          state_nxt = S_EMIT;
        end else begin
          ph_nxt = PH_W'(ph_r + 1'b1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = (k_r == n_r) ? S_SHIFT : S_STEP;
        end
      end
      S_SHIFT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (load_first || load_curve) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ph_r         <= '0;
      k_r          <= '0;
      seen_r       <= '0;
      first_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ph_r         <= ph_nxt;
      k_r          <= k_nxt;
      seen_r       <= seen_nxt;
      first_done_r <= first_done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tension_r <= TENSION_RST;
      subdiv_r  <= SUBDIV_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TENSION: tension_r <= cfg_wdata[TENSION_W-1:0];
        REG_SUBDIV:  subdiv_r  <= cfg_wdata[SUBDIV_W-1:0];
        default: ;
      endcase
    end
  end

  // sliding window, oldest point at index 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_x_r[i] <= '0;
        win_y_r[i] <= '0;
      end
    end else if (in_fire && (seen_eff != WIN_FULL)) begin
      win_x_r[seen_eff] <= in_ch.point_x;
      win_y_r[seen_eff] <= in_ch.point_y;
    end else if (state_r == S_SHIFT) begin
      win_x_r[0] <= win_x_r[1];
      win_y_r[0] <= win_y_r[1];
      win_x_r[1] <= win_x_r[2];
      win_y_r[1] <= win_y_r[2];
      win_x_r[2] <= px_r;
      win_y_r[2] <= py_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      px_r <= in_ch.point_x;
      py_r <= in_ch.point_y;
      n_r  <= n_eff;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_first) begin
      curve_x_r <= win_x_r[1];
      curve_y_r <= win_y_r[1];
      run_end_r <= (n_r == '0);
    end else if (load_curve) begin
      curve_x_r <= dp_x;
      curve_y_r <= dp_y;
      run_end_r <= (k_r == n_r);
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.curve_x = curve_x_r;
  assign out_ch.curve_y = curve_y_r;
  assign out_ch.run_end = run_end_r;

  assign quad_x = '{p0: win_x_r[0], p1: win_x_r[1], p2: win_x_r[2], p3: px_r};
  assign quad_y = '{p0: win_y_r[0], p1: win_y_r[1], p2: win_y_r[2], p3: py_r};

  assign dp_ctrl = '{setup: (state_r == S_SETUP), eval: (state_r == S_EVAL), phase: ph_r};

  csp_tgen #(
    .N_W (N_W)
  ) u_tgen (
    .clk   (clk),
    .rst_n (rst_n),
    .start ((state_r == S_SETUP) && (ph_r == SU_LATCH)),
    .step  (state_r == S_STEP),
    .n     (n_r),
    .ready (t_ready),
    .t     (t_val)
  );

  csp_dp u_dp (
    .clk     (clk),
    .ctrl    (dp_ctrl),
    .tension (tension_r),
    .t       (t_val),
    .quad_x  (quad_x),
    .quad_y  (quad_y),
    .curve_x (dp_x),
    .curve_y (dp_y)
  );

  `CSP_ASSERT_NOW(a_setup_needs_curve, state_r == S_SETUP,
                  first_done_r && (n_r != '0), "setup entered without a pending curve")
  `CSP_ASSERT_NOW(a_t_valid_in_eval, (state_r == S_STEP) || (state_r == S_EVAL),
                  t_ready, "t used while divider busy")
  `CSP_ASSERT_NOW(a_last_t_is_one, (state_r == S_EMIT) && (k_r == n_r),
                  t_val == T_ONE, "last curve point not at t = 1")
  `CSP_ASSERT_NEXT(a_emit_continues, load_curve && (k_r != n_r),
                   state_r == S_STEP, "curve run ended early")

endmodule

/* hw/rtl/csp_tgen.sv */
// Parameter t generator: 65536/N by restoring division, then t = floor(k*65536/N) steps.
module csp_tgen import csp_pkg::*; #(
  parameter int N_W = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           step,
  input  logic [N_W-1:0] n,
  output logic           ready,
  output tval_t          t
);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  tval_t            q_r;
  tval_t            t_r;
  logic [N_W-1:0]   rem_r;
  logic [N_W-1:0]   acc_r;
  logic             div_bit;
  logic [N_W:0]     trial;
  logic [N_W:0]     sum;

  // dividend is 2^16: only its top bit is set
  assign div_bit = (cnt_r == CNT_W'(T_W - 1));
  assign trial   = {rem_r, div_bit};
  assign sum     = {1'b0, acc_r} + {1'b0, rem_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(T_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= '0;
      t_r   <= '0;
      acc_r <= '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, n}) begin
        rem_r <= N_W'(trial - {1'b0, n});
        q_r   <= {q_r[T_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[N_W-1:0];
        q_r   <= {q_r[T_W-2:0], 1'b0};
      end
    end else if (step) begin
      // remainder accumulates below 2N: one compare and subtract
      if (sum >= {1'b0, n}) begin
        acc_r <= N_W'(sum - {1'b0, n});
        t_r   <= t_r + q_r + T_W'(1);
      end else begin
        acc_r <= sum[N_W-1:0];
        t_r   <= t_r + q_r;
      end
    end
  end

  assign ready = !busy_r;
  assign t     = t_r;

endmodule

/* hw/rtl/csp_dp.sv */
// Shared multiplier datapath: cardinal coefficients, Horner evaluation, rounding.
module csp_dp import csp_pkg::*; (
  input  logic                 clk,
  input  csp_dp_ctrl_t         ctrl,
  input  logic [TENSION_W-1:0] tension,
  input  tval_t                t,
  input  csp_quad_t            quad_x,
  input  csp_quad_t            quad_y,
  output coord_t               curve_x,
  output coord_t               curve_y
);

  localparam int DIFF_W = 20;

  typedef struct packed {
    logic signed [DIFF_W-1:0] da;
    logic signed [DIFF_W-1:0] db;
    logic signed [DIFF_W-1:0] dg;
    coef_t                    sa;
    coef_t                    sb;
    coef_t                    d;
  } diff_t;

  // A = C*da + sa, B = C*db + sb, G = C*dg, D = d (all scaled by 2^14)
  function automatic diff_t setup_terms(csp_quad_t q);
    logic signed [DIFF_W-1:0] e0;
    logic signed [DIFF_W-1:0] e1;
    logic signed [DIFF_W-1:0] e2;
    logic signed [DIFF_W-1:0] e3;
    logic signed [DIFF_W-1:0] dd;
    diff_t                    r;
    e0   = DIFF_W'($signed(q.p0));
    e1   = DIFF_W'($signed(q.p1));
    e2   = DIFF_W'($signed(q.p2));
    e3   = DIFF_W'($signed(q.p3));
    dd   = e2 - e1;
    r.da = e3 - e0 - e1 + e2;
    r.db = (e0 <<< 1) + e1 - (e2 <<< 1) - e3;
    r.dg = e2 - e0;
    r.sa = -(coef_t'(dd) <<< 15);
    r.sb = (coef_t'(dd) <<< 15) + (coef_t'(dd) <<< 14);
    r.d  = coef_t'(e1) <<< FRAC_SHIFT;
    return r;
  endfunction

  function automatic coord_t round_sat(coef_t v);
    coef_t r;
    r = (v + coef_t'(ROUND_BIAS)) >>> FRAC_SHIFT;
    if (r > coef_t'(32767)) begin
      return coord_t'(32767);
    end else if (r < coef_t'(-32768)) begin
      return coord_t'(-32768);
    end
    return COORD_W'(r);
  endfunction

  diff_t                    dx_r;
  diff_t                    dy_r;
  coef_t                    a_x_r;
  coef_t                    a_y_r;
  coef_t                    b_x_r;
  coef_t                    b_y_r;
  coef_t                    g_x_r;
  coef_t                    g_y_r;
  coef_t                    h_x_r;
  coef_t                    h_y_r;
  logic signed [PROD_W-1:0] prod_r;

  coef_t                    mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic                     mul_en;
  coef_t                    add_a;
  coef_t                    add_b;
  coef_t                    add_res;

  always_comb begin
    mul_a  = '0;
    mul_en = 1'b0;
    mul_b  = ctrl.eval ? MULB_W'(t) : MULB_W'(tension);
    if (ctrl.setup) begin
      mul_en = 1'b1;
      unique case (ctrl.phase)
        SU_MUL_AX: mul_a = coef_t'(dx_r.da);
        SU_MUL_AY: mul_a = coef_t'(dy_r.da);
        SU_MUL_BX: mul_a = coef_t'(dx_r.db);
        SU_MUL_BY: mul_a = coef_t'(dy_r.db);
        SU_MUL_GX: mul_a = coef_t'(dx_r.dg);
        SU_MUL_GY: mul_a = coef_t'(dy_r.dg);
        default:   mul_en = 1'b0;
      endcase
    end else if (ctrl.eval) begin
      mul_en = 1'b1;
      unique case (ctrl.phase)
        EV_MUL_AX:  mul_a = a_x_r;
        EV_MUL_AY:  mul_a = a_y_r;
        EV_MUL_HX1: mul_a = h_x_r;
        EV_MUL_HY1: mul_a = h_y_r;
        EV_MUL_HX2: mul_a = h_x_r;
        EV_MUL_HY2: mul_a = h_y_r;
        default:    mul_en = 1'b0;
      endcase
    end
  end

  // one adder: product (floored by 2^16 in Horner steps) plus a selected term
  always_comb begin
    add_b = '0;
    if (ctrl.eval) begin
      add_a = $signed(prod_r[COEF_W+HORNER_SHIFT-1:HORNER_SHIFT]);
      unique case (ctrl.phase)
        EV_MUL_AY:  add_b = b_x_r;
        EV_MUL_HX1: add_b = b_y_r;
        EV_MUL_HY1: add_b = g_x_r;
        EV_MUL_HX2: add_b = g_y_r;
        EV_MUL_HY2: add_b = dx_r.d;
        EV_LAST:    add_b = dy_r.d;
        default:    add_b = '0;
      endcase
    end else begin
      add_a = $signed(prod_r[COEF_W-1:0]);
      unique case (ctrl.phase)
        SU_MUL_AY: add_b = dx_r.sa;
        SU_MUL_BX: add_b = dy_r.sa;
        SU_MUL_BY: add_b = dx_r.sb;
        SU_MUL_GX: add_b = dy_r.sb;
        default:   add_b = '0;
      endcase
    end
    add_res = add_a + add_b;
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (ctrl.setup) begin
      unique case (ctrl.phase)
        SU_LATCH: begin
          dx_r <= setup_terms(quad_x);
          dy_r <= setup_terms(quad_y);
        end
        SU_MUL_AY: a_x_r <= add_res;
        SU_MUL_BX: a_y_r <= add_res;
        SU_MUL_BY: b_x_r <= add_res;
        SU_MUL_GX: b_y_r <= add_res;
        SU_MUL_GY: g_x_r <= add_res;
        SU_LAST:   g_y_r <= add_res;
        default: ;
      endcase
    end
    if (ctrl.eval) begin
      unique case (ctrl.phase)
        EV_MUL_AY:  h_x_r <= add_res;
        EV_MUL_HX1: h_y_r <= add_res;
        EV_MUL_HY1: h_x_r <= add_res;
        EV_MUL_HX2: h_y_r <= add_res;
        EV_MUL_HY2: h_x_r <= add_res;
        EV_LAST:    h_y_r <= add_res;
        default: ;
      endcase
    end
  end

  assign curve_x = round_sat(h_x_r);
  assign curve_y = round_sat(h_y_r);

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the cardinal spline point generator.
module testbench;
  import csp_pkg::*;

  // A stretch this long with no handshake on any port means the block is stuck.
  localparam int WATCHDOG_LIMIT = 4000;
  // Idle cycles after the last curve point before touching the registers.
  // This covers the window slide and items that make no curve points.
  localparam int SETTLE_CYCLES  = 64;
  // The receiver holds ready low this long once, so that the block backs up.
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 40;
  localparam int NUM_PHASES     = 8;
  localparam int DIR_ROWS       = 23;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } curve_pt_t;

  typedef enum logic [1:0] {ROW_POINT, ROW_CFG} row_kind_t;
  // How a directed row is checked: against the predictor, as an item that
  // makes no curve point, or as one that makes only the lead point.
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_LEAD} row_chk_t;

  typedef struct packed {
    row_kind_t            kind;
    row_chk_t             chk;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [15:0]          wdata;
    coord_t               px;
    coord_t               py;
    logic                 st;
    coord_t               lead_x;
    coord_t               lead_y;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  csp_point_if in_ch ();
  csp_curve_if out_ch ();

  cardinal_spline_point_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state: registers, the three-point window and track progress.
  logic [TENSION_W-1:0] cur_tension = TENSION_RST;
  logic [SUBDIV_W-1:0]  cur_subdiv  = SUBDIV_RST;
  longint win_x [3] = '{0, 0, 0};
  longint win_y [3] = '{0, 0, 0};
  int     pts_held  = 0;
  bit     lead_done = 0;

  curve_pt_t curve_due [$];   // curve points still owed by the block, oldest first

  int errors       = 0;
  int items_sent   = 0;
  int curve_seen   = 0;
  int reg_writes   = 0;
  int send_pct     = 0;       // percent of cycles the sender stays idle
  int recv_pct     = 0;       // percent of cycles the receiver stalls
  int hold_ask     = 0;       // bumped by the stimulus to request one long hold
  int idle_cycles  = 0;

  // Directed table. Rows that only fill the window, or that make nothing but
  // the lead point, carry their expectation; the rest go to the predictor.
  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    // fresh track at reset settings: three fills, then first segment
    '{ROW_POINT, CHK_NONE,  REG_TENSION, 16'h0, 16'h0000, 16'h0000, 1'b1, 16'h0, 16'h0},
    '{ROW_POINT, CHK_NONE,  REG_TENSION, 16'h0, 16'h0010, 16'h0010, 1'b0, 16'h0, 16'h0},
    '{ROW_POINT, CHK_NONE,  REG_TENSION, 16'h0, 16'h0020, 16'h0020, 1'b0, 16'h0, 16'h0},
    '{ROW_POINT, CHK_MODEL, REG_TENSION, 16'h0, 16'h0030, 16'h0030, 1'b0, 16'h0, 16'h0},
    '{ROW_POINT, CHK_MODEL, REG_TENSION, 16'h0, 16'h0040, 16'hFFC0, 1'b0, 16'h0, 16'h0},
    // zero subdivisions: first segment gives only the lead point, then nothing
    '{ROW_CFG,   CHK_NONE,  REG_SUBDIV,  16'd0, 16'h0000, 16'h0000, 1'b0, 16'h0, 16'h0},
    '{ROW_POINT, CHK_NONE,  REG_TENSION, 16'h0, 16'h7FFF, 16'h8000, 1'b1, 16'h0, 16'h0},
    '{ROW_POINT, CHK_NONE,  REG_TENSION, 16'h0, 16'h8000, 16'h7FFF, 1'b0, 16'h0, 16'h0},
    '{ROW_POINT, CHK_NONE,  REG_TENSION, 16'h0, 16'h0064, 16'h00C8, 1'b0, 16'h0, 16'h0},
    '{ROW_POINT, CHK_LEAD,  REG_TENSION, 16'h0, 16'h0005, 16'h0005, 1'b0,
      16'h8000, 16'h7FFF},
    '{ROW_POINT, CHK_NONE,  REG_TENSION, 16'h0, 16'h0007, 16'h0007, 1'b0, 16'h0, 16'h0},
    // single subdivision: the segment end only
    '{ROW_CFG,   CHK_NONE,  REG_SUBDIV,  16'd1, 16'h0000, 16'h0000, 1'b0, 16'h0, 16'h0},
    '{ROW_POINT, CHK_MODEL, REG_TENSION, 16'h0, 16'hFFFF, 16'h0001, 1'b0, 16'h0, 16'h0},
    // zero tension: straight segments
    '{ROW_CFG,   CHK_NONE,  REG_TENSION, 16'h0, 16'h0000, 16'h0000, 1'b0, 16'h0, 16'h0},
    '{ROW_POINT, CHK_MODEL, REG_TENSION, 16'h0, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0, 16'h0},
    // top tension and most subdivisions with full-swing points: saturation
    '{ROW_CFG,   CHK_NONE,  REG_TENSION, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 16'h0, 16'h0},
    '{ROW_CFG,   CHK_NONE,  REG_SUBDIV,  16'd63, 16'h0000, 16'h0000, 1'b0, 16'h0, 16'h0},
    '{ROW_POINT, CHK_MODEL, REG_TENSION, 16'h0, 16'h8000, 16'h8000, 1'b0, 16'h0, 16'h0},
    '{ROW_POINT, CHK_MODEL, REG_TENSION, 16'h0, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0, 16'h0},
    '{ROW_CFG,   CHK_NONE,  REG_TENSION, 16'h8000, 16'h0000, 16'h0000, 1'b0, 16'h0, 16'h0},
    '{ROW_POINT, CHK_MODEL, REG_TENSION, 16'h0, 16'h8000, 16'h7FFF, 1'b0, 16'h0, 16'h0},
    // new track in the middle of a full window: back to filling
    '{ROW_POINT, CHK_NONE,  REG_TENSION, 16'h0, 16'h0001, 16'h0002, 1'b1, 16'h0, 16'h0},
    '{ROW_POINT, CHK_NONE,  REG_TENSION, 16'h0, 16'h0003, 16'h0004, 1'b0, 16'h0, 16'h0}
  };

  // Random phase settings; the second and the fifth hit the tension extremes.
  logic [15:0] phase_tension [0:NUM_PHASES-1] =
    '{16'd8192, 16'd0, 16'd16384, 16'd32768, 16'hFFFF, 16'd12000, 16'd5000, 16'd20000};
  logic [15:0] phase_subdiv  [0:NUM_PHASES-1] =
    '{16'd16, 16'd4, 16'd8, 16'd1, 16'd3, 16'd63, 16'd0, 16'd2};

  task automatic report_bad(string what, int got, int want);
    $display("mismatch: %s got %0d want %0d (curve point %0d)", what, got, want, curve_seen);
    errors++;
  endtask

  // Queue one curve point behind those already owed.
  function automatic void owe_point(curve_pt_t pt);
    curve_due.insert(curve_due.size(), pt);
  endfunction

  // One axis of the cardinal cubic at t (Q0.16): coefficients scaled by 2^14,
  // Horner with a floor at each stage, then round to nearest and saturate.
  function automatic coord_t curve_axis(longint c, longint p0, longint p1, longint p2,
                                        longint p3, longint t);
    longint a, b, g, d, h;
    a = c * (p3 - p0) + (32768 - c) * (p1 - p2);
    b = 2 * c * p0 + (c - 49152) * p1 + (49152 - 2 * c) * p2 - c * p3;
    g = c * (p2 - p0);
    d = p1 * 16384;
    h = (a * t) >>> HORNER_SHIFT;
    h = ((h + b) * t) >>> HORNER_SHIFT;
    h = ((h + g) * t) >>> HORNER_SHIFT;
    h = (h + d + ROUND_BIAS) >>> FRAC_SHIFT;
    if (h > 32767)
      return 16'sh7FFF;
    if (h < -32768)
      return 16'sh8000;
    return coord_t'(h);
  endfunction

  // Advance the predictor by one accepted control point and queue the curve
  // points it owes.
  task automatic predict_point(coord_t x, coord_t y, logic st);
    longint    c, t, sub;
    curve_pt_t pt;
    if (st) begin
      pts_held  = 0;
      lead_done = 0;
    end
    if (pts_held < 3) begin
      win_x[pts_held] = x;
      win_y[pts_held] = y;
      pts_held++;
      return;
    end
    sub = longint'(cur_subdiv);
    c   = longint'(cur_tension);
    // the track's first segment is led by its second control point
    if (!lead_done) begin
      pt.x      = coord_t'(win_x[1]);
      pt.y      = coord_t'(win_y[1]);
      pt.last   = (sub == 0);
      owe_point(pt);
      lead_done = 1;
    end
    for (longint k = 1; k <= sub; k++) begin
      t       = (k * 65536) / sub;
      pt.x    = curve_axis(c, win_x[0], win_x[1], win_x[2], longint'(x), t);
      pt.y    = curve_axis(c, win_y[0], win_y[1], win_y[2], longint'(y), t);
      pt.last = (k == sub);
      owe_point(pt);
    end
    win_x[0] = win_x[1];
    win_y[0] = win_y[1];
    win_x[1] = win_x[2];
    win_y[1] = win_y[2];
    win_x[2] = x;
    win_y[2] = y;
  endtask

  // Offer one control point, wait for the handshake, then predict. Directed
  // rows with a typed expectation replace what the predictor queued.
  task automatic send_point(coord_t x, coord_t y, logic st, row_chk_t chk,
                            coord_t lx, coord_t ly);
    int        before_n;
    curve_pt_t pt;
    while ($urandom_range(99) < send_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.point_x     <= x;
    in_ch.point_y     <= y;
    in_ch.start_track <= st;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    before_n = curve_due.size();
    predict_point(x, y, st);
    if (chk != CHK_MODEL) begin
      while (curve_due.size() > before_n)
        void'(curve_due.pop_back());
      if (chk == CHK_LEAD) begin
        pt.x    = lx;
        pt.y    = ly;
        pt.last = 1'b1;
        owe_point(pt);
      end
    end
    items_sent++;
  endtask

  // Let the block go idle: no item offered, every curve point in, then settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (curve_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TENSION)
      cur_tension = data;
    else
      cur_subdiv = data[SUBDIV_W-1:0];
    reg_writes++;
    @(posedge clk);
  endtask

  // Mostly a short walk from the previous point, sometimes anywhere, sometimes
  // right on a rail.
  function automatic coord_t rand_coord(coord_t prev);
    int pick;
    pick = $urandom_range(19);
    if (pick < 14)
      return prev + coord_t'($urandom_range(1023)) - 16'sd512;
    if (pick < 17)
      return coord_t'($urandom);
    if (pick == 17)
      return 16'sh7FFF;
    if (pick == 18)
      return 16'sh8000;
    return 16'sh0000;
  endfunction

  // Random tracks: mostly well-formed runs of 4..12 points, with now and then
  // a broken track of one to three points cut short by the next start.
  task automatic run_tracks(int n_items);
    int     sent, len;
    coord_t x, y;
    sent = 0;
    x    = coord_t'($urandom);
    y    = coord_t'($urandom);
    while (sent < n_items) begin
      if ($urandom_range(9) == 0)
        len = $urandom_range(1, 3);
      else
        len = $urandom_range(4, 12);
      for (int i = 0; i < len && sent < n_items; i++) begin
        x = rand_coord(x);
        y = rand_coord(y);
        send_point(x, y, (i == 0), CHK_MODEL, 16'sh0, 16'sh0);
        sent++;
      end
    end
  endtask

  // Receiver: random stalls at recv_pct, plus one long hold when asked.
  initial begin
    int hold_seen, hold_left;
    hold_seen    = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_ask) begin
        hold_seen = hold_ask;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  // Checker: each curve point against the oldest one owed.
  always @(posedge clk) begin
    curve_pt_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (curve_due.size() == 0) begin
        report_bad("curve point with none owed, curve_x", out_ch.curve_x, 0);
      end else begin
        want = curve_due.pop_front();
        if (out_ch.curve_x !== want.x)
          report_bad("curve_x", out_ch.curve_x, want.x);
        if (out_ch.curve_y !== want.y)
          report_bad("curve_y", out_ch.curve_y, want.y);
        if (out_ch.run_end !== want.last)
          report_bad("run_end", out_ch.run_end, want.last);
      end
      curve_seen++;
    end
  end

  // Watchdog: any handshake or register write resets the count.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_TENSION;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.point_x     <= '0;
    in_ch.point_y     <= '0;
    in_ch.start_track <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling; register rows wait for the block to go idle.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].wdata);
      end else begin
        send_point(dir_rows[i].px, dir_rows[i].py, dir_rows[i].st, dir_rows[i].chk,
                   dir_rows[i].lead_x, dir_rows[i].lead_y);
      end
    end

    // Random phases: new settings each time, cycling through the idle modes.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_reg(REG_TENSION, phase_tension[p]);
      write_reg(REG_SUBDIV, phase_subdiv[p]);
      case (p % 4)
        0: begin
          send_pct = 0;
          recv_pct = 0;
        end
        1: begin
          send_pct = 47;
          recv_pct = 0;
        end
        2: begin
          send_pct = 0;
          recv_pct = 47;
        end
        default: begin
          send_pct = 32;
          recv_pct = 32;
        end
      endcase
      // back-pressure: receiver holds off while the sender keeps offering
      if (p == 2)
        hold_ask++;
      run_tracks(PHASE_ITEMS);
    end

    in_ch.valid <= 1'b0;
    send_pct = 0;
    recv_pct = 0;
    while (curve_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (curve_due.size() != 0) begin
      $display("mismatch: %0d curve points never arrived", curve_due.size());
      errors++;
    end

    $display("summary: %0d control points in, %0d curve points checked, %0d mismatches",
             items_sent, curve_seen, errors);
    $display("summary: %0d register writes, tension 0..65535, subdivisions 0..63",
             reg_writes);
    if (errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
